/* rtl/ttw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared types and constants of the text-mode terminal writer: request and
// result payloads, function codes, control characters and register map.
// ----------------------------------------------------------------------------
package ttw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // function codes
  localparam logic [1:0] FUNC_PUT    = 2'd0;
  localparam logic [1:0] FUNC_PUT_AT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // control characters
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_NUL       = 8'd0;

  localparam logic [7:0] COLOUR_RESET = 8'h0F;

  // configuration port
  localparam int         PADDR_W         = 3;
  localparam logic       REG_TEXT_COLOUR = 1'b0;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [7:0] cell_colour;
    logic [6:0] target_col;
    logic [4:0] target_row;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_offset;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } rsp_t;

endpackage

/* rtl/text_mode_terminal_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Character-cell screen store with a cursor, fed by put-character, put-at
// and clear requests; reports the cursor after every request.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. Its
//   result (cursor offset, row, column, scrolled flag) appears on rsp for
//   exactly one cycle with done high, in the cycle after the request; the
//   receiver cannot stall it.
//   Ordinary put-character without scroll and on-screen put-at write one cell
//   through the store's write port in the accept cycle; busy stays low.
//   A scroll or a clear runs a sweep of the screen store, one cell per
//   cycle; a scroll reads a row ahead and writes each cell in the cycle
//   after its read. busy stays high until the last cell is written back.
//   After reset the same sweep fills the store with spaces in colour 0x0F;
//   busy stays high until it ends, so no request is taken before that.
//   text_colour is written over the APB-style port at byte addresses 0 to 3.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
  parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  ttw_pkg::req_t               req,
  output logic                        done,
  output ttw_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ttw_pkg::*;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int SHIFT_END = CELLS - COLUMNS;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } state_t;

  state_t            state;
  logic [CELL_W-1:0] idx;
  logic              fill_mode;
  logic [15:0]       fill_cell;
  logic              pend_valid;
  logic              pend_fill;
  logic [CELL_W-1:0] pend_addr;
  logic [7:0]        text_colour;

  logic [15:0]       cells [CELLS];
  logic [CELL_W-1:0] rd_addr;
  logic [15:0]       rd_data;
  logic              we;
  logic [CELL_W-1:0] waddr;
  logic [15:0]       wdata;

  logic              accept;
  logic              put;
  logic              ordinary;
  logic              at_valid;
  logic              scroll;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic [CELL_W-1:0] cur_addr;
  logic [CELL_W-1:0] at_addr;
  logic [CELL_W-1:0] off_next;

  assign busy   = (state != ST_IDLE) || pend_valid;
  assign accept = start && !busy;
  assign put    = accept && (req.func == FUNC_PUT);

  assign ordinary = (req.char_code != CH_NEWLINE) && (req.char_code != CH_RETURN) &&
                    (req.char_code != CH_BACKSPACE);
  assign at_valid = (32'(req.target_col) < COLUMNS) && (32'(req.target_row) < ROWS);

  assign cur_addr = CELL_W'(row) * CELL_W'(COLUMNS) + CELL_W'(col);
  assign at_addr  = CELL_W'(req.target_row) * CELL_W'(COLUMNS) + CELL_W'(req.target_col);
  assign off_next = CELL_W'(row_next) * CELL_W'(COLUMNS) + CELL_W'(col_next);

  ttw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .step      (put),
    .char_code (req.char_code),
    .row       (row),
    .col       (col),
    .row_next  (row_next),
    .col_next  (col_next),
    .scroll    (scroll)
  );

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_COLOUR) ? 32'(text_colour) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_colour <= COLOUR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOUR)) begin
      text_colour <= pwdata[7:0];
    end
  end

  // write port: sweep write-back, else the cell a request names
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {text_colour, req.char_code};
    if (pend_valid) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = pend_fill ? fill_cell : rd_data;
    end else if (put && ordinary) begin
      we = 1'b1;
    end else if (accept && (req.func == FUNC_PUT_AT) && at_valid) begin
      we    = 1'b1;
      waddr = at_addr;
      wdata = {req.cell_colour, req.char_code};
    end
  end

  // read one row ahead of the write-back during a scroll
  always_comb begin
    rd_addr = '0;
    if ((state == ST_SWEEP) && !fill_mode && (32'(idx) < SHIFT_END)) begin
      rd_addr = idx + CELL_W'(COLUMNS);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= cells[rd_addr];
  end

  // sweep sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      idx        <= '0;
      fill_mode  <= 1'b1;
      fill_cell  <= {COLOUR_RESET, CH_SPACE};
      pend_valid <= 1'b0;
      pend_fill  <= 1'b0;
      pend_addr  <= '0;
    end else begin
      pend_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (put && scroll) begin
            state     <= ST_SWEEP;
            idx       <= '0;
            fill_mode <= 1'b0;
            fill_cell <= {text_colour, CH_NUL};
          end else if (accept && (req.func == FUNC_CLEAR)) begin
            state     <= ST_SWEEP;
            idx       <= '0;
            fill_mode <= 1'b1;
            fill_cell <= {text_colour, CH_SPACE};
          end
        end
        ST_SWEEP: begin
          pend_valid <= 1'b1;
          pend_addr  <= idx;
          pend_fill  <= fill_mode || (32'(idx) >= SHIFT_END);
          if (idx == CELL_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.cursor_offset <= 11'(off_next);
      rsp.cursor_row    <= 5'(row_next);
      rsp.cursor_col    <= 7'(col_next);
      rsp.scrolled      <= put && scroll;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request without result");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result without request");

  a_scroll_sweeps: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.scrolled) |-> (state == ST_SWEEP))
    else $error("scroll reported without sweep");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !accept)
    else $error("request taken during sweep write-back");
`endif

endmodule

/* rtl/ttw_cursor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_cursor
// Cursor registers and the put-character movement rules: newline, return,
// backspace and advance with wrap. Flags a scroll when the cursor passes
// the bottom row.
// ----------------------------------------------------------------------------
module ttw_cursor #(
  parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [7:0]                 char_code,
  output logic [$clog2(ROWS)-1:0]    row,
  output logic [$clog2(COLUMNS)-1:0] col,
  output logic [$clog2(ROWS)-1:0]    row_next,
  output logic [$clog2(COLUMNS)-1:0] col_next,
  output logic                       scroll
);
  import ttw_pkg::*;

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

  logic last_row;
  logic last_col;

  assign last_row = (row == ROW_LAST);
  assign last_col = (col == COL_LAST);

  always_comb begin
    row_next = row;
    col_next = col;
    scroll   = 1'b0;
    if (step) begin
      case (char_code)
        CH_NEWLINE: begin
          col_next = '0;
          if (last_row) begin
            scroll = 1'b1;
          end else begin
            row_next = row + 1'b1;
          end
        end
        CH_RETURN: begin
          col_next = '0;
        end
        CH_BACKSPACE: begin
          // stop at the top-left cell
          if (col != '0) begin
            col_next = col - 1'b1;
          end else if (row != '0) begin
            row_next = row - 1'b1;
            col_next = COL_LAST;
          end
        end
        default: begin
          if (last_col) begin
            col_next = '0;
            if (last_row) begin
              scroll = 1'b1;
            end else begin
              row_next = row + 1'b1;
            end
          end else begin
            col_next = col + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    32'(row) < ROWS)
    else $error("cursor row out of range");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(col) < COLUMNS)
    else $error("cursor column out of range");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    scroll |=> (row == ROW_LAST))
    else $error("cursor left bottom row on scroll");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(row) && $stable(col)))
    else $error("cursor moved without a request");
`endif

endmodule
